@@ rtl/xtt_pkg.sv @@
// ----------------------------------------------------------------------------
// xtt_pkg
// Shared types and constants of the XML tag tokenizer.
// ----------------------------------------------------------------------------
package xtt_pkg;

    localparam int MAX_DEPTH_DEF = 16;
    localparam int MAX_NAME_DEF  = 32;
    localparam int LINE_W        = 20;
    localparam logic [LINE_W-1:0] LINE_MAX = 20'hFFFFF;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QM    = 8'h3F;
    localparam logic [7:0] CH_EXCL  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_RBR   = 8'h5D;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_START = 3'd1,
        EV_END   = 3'd2,
        EV_ATTR  = 3'd3,
        EV_EOT   = 3'd4,
        EV_ERROR = 3'd5
    } event_t;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_ATTR_SP   = 4'd1,
        ERR_BAD_QUOTE = 4'd2,
        ERR_BAD_SLASH = 4'd3,
        ERR_MISMATCH  = 4'd4,
        ERR_END_GARB  = 4'd5,
        ERR_COMMENT   = 4'd6,
        ERR_UNDERFLOW = 4'd7,
        ERR_OVERFLOW  = 4'd8,
        ERR_LONG_NAME = 4'd9
    } err_t;

    typedef enum logic [2:0] {
        ROLE_NONE  = 3'd0,
        ROLE_TAG   = 3'd1,
        ROLE_ANAME = 3'd2,
        ROLE_AVAL  = 3'd3,
        ROLE_ETAG  = 3'd4
    } role_t;

    typedef enum logic [4:0] {
        ST_OUT     = 5'd0,
        ST_LT      = 5'd1,
        ST_NAME    = 5'd2,
        ST_SPACE   = 5'd3,
        ST_ANAME   = 5'd4,
        ST_EQ      = 5'd5,
        ST_VAL     = 5'd6,
        ST_SLASH   = 5'd7,
        ST_ETAG    = 5'd8,
        ST_ETAG_SP = 5'd9,
        ST_PI      = 5'd10,
        ST_PI_Q    = 5'd11,
        ST_DECL    = 5'd12,
        ST_DECL2   = 5'd13,
        ST_CM0     = 5'd14,
        ST_CM      = 5'd15,
        ST_CM1     = 5'd16,
        ST_CM2     = 5'd17,
        ST_BR      = 5'd18,
        ST_BRQ     = 5'd19,
        ST_DQ      = 5'd20
    } st_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
        logic       newline;
        logic       ctl;
    } item_t;

    typedef struct packed {
        event_t             event_res;
        err_t               error_code;
        logic [4:0]         depth;
        role_t              byte_role;
        logic [7:0]         role_byte;
        logic [LINE_W-1:0]  line_number;
    } res_t;

endpackage

@@ rtl/xtt_fifo.sv @@
// ----------------------------------------------------------------------------
// xtt_fifo
// Two-entry queue that decouples producer and consumer.
// ----------------------------------------------------------------------------
module xtt_fifo #(
    parameter int W = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         empty
);
    logic [W-1:0] mem_reg [2];
    logic         wp_reg;
    logic         wp_next;
    logic         rp_reg;
    logic         rp_next;
    logic [1:0]   cnt_reg;
    logic [1:0]   cnt_next;
    logic         do_wr;
    logic         do_rd;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = mem_reg[rp_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wp_next  = do_wr ? ~wp_reg : wp_reg;
        rp_next  = do_rd ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end
endmodule

@@ rtl/xtt_front.sv @@
// ----------------------------------------------------------------------------
// xtt_front
// Accepts input transactions, classifies the byte and queues the item.
// ----------------------------------------------------------------------------
module xtt_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [7:0]    text_byte,
    input  logic          end_of_text,
    output logic          full,
    output logic          item_valid,
    output xtt_pkg::item_t item,
    input  logic          item_take
);
    import xtt_pkg::*;

    item_t cls;
    logic  q_empty;

    always_comb
    begin
        cls.text_byte   = text_byte;
        cls.end_of_text = end_of_text;
        cls.newline     = (text_byte == CH_NL);
        cls.ctl         = (text_byte <= CH_SP);
    end

    xtt_fifo #(.W($bits(item_t))) u_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cls),
        .full    (full),
        .rd_en   (item_take),
        .rd_data (item),
        .empty   (q_empty)
    );

    assign item_valid = !q_empty;
endmodule

@@ rtl/xtt_back.sv @@
// ----------------------------------------------------------------------------
// xtt_back
// Tag state machine and name stack; one queued item per cycle unless res_full.
// ----------------------------------------------------------------------------
module xtt_back #(
    parameter int MAX_DEPTH = xtt_pkg::MAX_DEPTH_DEF,
    parameter int MAX_NAME  = xtt_pkg::MAX_NAME_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  xtt_pkg::item_t item,
    output logic           item_take,
    input  logic           res_full,
    output logic           res_wr,
    output xtt_pkg::res_t  res
);
    import xtt_pkg::*;

    localparam int DEP_W = $clog2(MAX_DEPTH + 1);
    localparam int TOP_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int NI_W  = $clog2(MAX_NAME + 2);
    localparam int LEN_W = (MAX_NAME > 1) ? $clog2(MAX_NAME + 1) : 1;
    localparam int MEM_D = MAX_DEPTH * MAX_NAME;
    localparam int AW    = (MEM_D > 1) ? $clog2(MEM_D) : 1;

    logic [7:0]        name_mem [MEM_D];
    logic [7:0]        rd_reg;
    logic [LEN_W-1:0]  len_reg [MAX_DEPTH];

    st_t               st_reg,   st_next;
    logic              pend_reg, pend_next;
    logic [DEP_W-1:0]  dep_reg,  dep_next;
    logic [NI_W-1:0]   ni_reg,   ni_next;
    logic              mis_reg,  mis_next;
    err_t              err_reg,  err_next;
    logic [LINE_W-1:0] line_reg, line_next;

    logic              adv;
    event_t            ev;
    role_t             role;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [AW-1:0]     mem_ra;
    logic              len_we;
    logic [TOP_W-1:0]  top;
    logic [7:0]        c;
    logic              done;

    assign adv       = item_valid && !res_full;
    assign item_take = adv;
    assign res_wr    = adv;
    assign c         = item.text_byte;

    always_comb
    begin
        st_next   = st_reg;
        pend_next = pend_reg;
        dep_next  = dep_reg;
        ni_next   = ni_reg;
        mis_next  = mis_reg;
        err_next  = err_reg;
        line_next = line_reg;
        ev        = EV_NONE;
        role      = ROLE_NONE;
        mem_we    = 1'b0;
        len_we    = 1'b0;
        done      = 1'b0;
        top       = TOP_W'(dep_reg - DEP_W'(1));
        if (adv)
        begin
            if (!item.end_of_text && item.newline && line_reg != LINE_MAX)
            begin
                line_next = line_reg + LINE_W'(1);
            end
            if (err_reg != ERR_NONE)
            begin
                ev   = EV_ERROR;
                done = 1'b1;
            end
            if (!done && pend_reg)
            begin
                pend_next = 1'b0;
                if (dep_reg == '0)
                begin
                    err_next = ERR_UNDERFLOW;
                    ev       = EV_ERROR;
                    done     = 1'b1;
                end
                else
                begin
                    dep_next = dep_reg - DEP_W'(1);
                end
            end
            top = TOP_W'(dep_next - DEP_W'(1));
            if (!done && item.end_of_text)
            begin
                ev   = EV_EOT;
                done = 1'b1;
            end
            if (!done)
            begin
                case (st_reg)
                    ST_LT:
                    begin
                        if (c == CH_SLASH)
                        begin
                            st_next  = ST_ETAG;
                            ni_next  = '0;
                            mis_next = 1'b0;
                        end
                        else if (c == CH_QM)
                        begin
                            st_next = ST_PI;
                        end
                        else if (c == CH_EXCL)
                        begin
                            st_next = ST_DECL;
                        end
                        else if (!item.ctl)
                        begin
                            if (dep_next >= DEP_W'(MAX_DEPTH))
                            begin
                                err_next = ERR_OVERFLOW;
                                ev       = EV_ERROR;
                            end
                            else
                            begin
                                mem_we  = 1'b1;
                                ni_next = NI_W'(1);
                                st_next = ST_NAME;
                                role    = ROLE_TAG;
                            end
                        end
                    end
                    ST_NAME:
                    begin
                        if (c == CH_GT || c == CH_SLASH || item.ctl)
                        begin
                            if (dep_next >= DEP_W'(MAX_DEPTH))
                            begin
                                err_next = ERR_OVERFLOW;
                                ev       = EV_ERROR;
                            end
                            else
                            begin
                                len_we   = 1'b1;
                                dep_next = dep_next + DEP_W'(1);
                                if (c == CH_GT)
                                begin
                                    st_next = ST_OUT;
                                    ev      = EV_START;
                                end
                                else if (c == CH_SLASH)
                                begin
                                    st_next = ST_SLASH;
                                    ev      = EV_START;
                                end
                                else
                                begin
                                    st_next = ST_SPACE;
                                end
                            end
                        end
                        else if (ni_reg >= NI_W'(MAX_NAME) ||
                                 dep_next >= DEP_W'(MAX_DEPTH))
                        begin
                            err_next = ERR_LONG_NAME;
                            ev       = EV_ERROR;
                        end
                        else
                        begin
                            mem_we  = 1'b1;
                            ni_next = ni_reg + NI_W'(1);
                            role    = ROLE_TAG;
                        end
                    end
                    ST_SPACE:
                    begin
                        if (c == CH_GT)
                        begin
                            st_next = ST_OUT;
                            ev      = EV_START;
                        end
                        else if (c == CH_SLASH)
                        begin
                            st_next = ST_SLASH;
                            ev      = EV_START;
                        end
                        else if (!item.ctl)
                        begin
                            st_next = ST_ANAME;
                            role    = ROLE_ANAME;
                        end
                    end
                    ST_ANAME:
                    begin
                        if (c == CH_EQ)
                        begin
                            st_next = ST_EQ;
                        end
                        else if (!item.ctl)
                        begin
                            role = ROLE_ANAME;
                        end
                        else
                        begin
                            err_next = ERR_ATTR_SP;
                            ev       = EV_ERROR;
                        end
                    end
                    ST_EQ:
                    begin
                        if (c == CH_DQ)
                        begin
                            st_next = ST_VAL;
                        end
                        else if (!item.ctl)
                        begin
                            err_next = ERR_BAD_QUOTE;
                            ev       = EV_ERROR;
                        end
                    end
                    ST_VAL:
                    begin
                        if (c == CH_DQ)
                        begin
                            st_next = ST_SPACE;
                            ev      = EV_ATTR;
                        end
                        else
                        begin
                            role = ROLE_AVAL;
                        end
                    end
                    ST_SLASH:
                    begin
                        if (c == CH_GT)
                        begin
                            st_next   = ST_OUT;
                            pend_next = 1'b1;
                            ev        = EV_END;
                        end
                        else
                        begin
                            err_next = ERR_BAD_SLASH;
                            ev       = EV_ERROR;
                        end
                    end
                    ST_ETAG, ST_ETAG_SP:
                    begin
                        if (c == CH_GT)
                        begin
                            if (dep_next == '0 || dep_next > DEP_W'(MAX_DEPTH))
                            begin
                                err_next = ERR_UNDERFLOW;
                                ev       = EV_ERROR;
                            end
                            else
                            begin
                                st_next = ST_OUT;
                                if (mis_reg || ni_reg != NI_W'(len_reg[top]))
                                begin
                                    err_next = ERR_MISMATCH;
                                    ev       = EV_ERROR;
                                end
                                else
                                begin
                                    pend_next = 1'b1;
                                    ev        = EV_END;
                                end
                            end
                        end
                        else if (!item.ctl)
                        begin
                            if (st_reg == ST_ETAG_SP)
                            begin
                                err_next = ERR_END_GARB;
                                ev       = EV_ERROR;
                            end
                            else
                            begin
                                if (dep_next == '0 || dep_next > DEP_W'(MAX_DEPTH))
                                begin
                                    mis_next = 1'b1;
                                end
                                else if (ni_reg >= NI_W'(len_reg[top]) ||
                                         ni_reg >= NI_W'(MAX_NAME) || rd_reg != c)
                                begin
                                    mis_next = 1'b1;
                                end
                                if (ni_reg <= NI_W'(MAX_NAME))
                                begin
                                    ni_next = ni_reg + NI_W'(1);
                                end
                                role = ROLE_ETAG;
                            end
                        end
                        else
                        begin
                            st_next = ST_ETAG_SP;
                        end
                    end
                    ST_PI:
                    begin
                        if (c == CH_QM)
                        begin
                            st_next = ST_PI_Q;
                        end
                    end
                    ST_PI_Q:
                    begin
                        st_next = (c == CH_GT) ? ST_OUT : ST_PI;
                    end
                    ST_DECL:
                    begin
                        if (c == CH_DASH)
                        begin
                            st_next = ST_CM0;
                        end
                        else if (c == CH_LBR)
                        begin
                            st_next = ST_BR;
                        end
                        else if (c == CH_DQ)
                        begin
                            st_next = ST_DQ;
                        end
                        else
                        begin
                            st_next = ST_DECL2;
                        end
                    end
                    ST_DECL2:
                    begin
                        if (c == CH_GT)
                        begin
                            st_next = ST_OUT;
                        end
                        else if (c == CH_LBR)
                        begin
                            st_next = ST_BR;
                        end
                        else if (c == CH_DQ)
                        begin
                            st_next = ST_DQ;
                        end
                    end
                    ST_CM0:
                    begin
                        if (c == CH_DASH)
                        begin
                            st_next = ST_CM;
                        end
                        else
                        begin
                            err_next = ERR_COMMENT;
                            ev       = EV_ERROR;
                        end
                    end
                    ST_CM:
                    begin
                        if (c == CH_DASH)
                        begin
                            st_next = ST_CM1;
                        end
                    end
                    ST_CM1:
                    begin
                        st_next = (c == CH_DASH) ? ST_CM2 : ST_CM;
                    end
                    ST_CM2:
                    begin
                        st_next = (c == CH_GT) ? ST_OUT : ST_CM;
                    end
                    ST_BR:
                    begin
                        if (c == CH_RBR)
                        begin
                            st_next = ST_DECL2;
                        end
                        else if (c == CH_DQ)
                        begin
                            st_next = ST_BRQ;
                        end
                    end
                    ST_BRQ:
                    begin
                        if (c == CH_DQ)
                        begin
                            st_next = ST_BR;
                        end
                    end
                    ST_DQ:
                    begin
                        if (c == CH_DQ)
                        begin
                            st_next = ST_DECL2;
                        end
                    end
                    default:
                    begin
                        st_next = (c == CH_LT) ? ST_LT : ST_OUT;
                    end
                endcase
            end
        end
        if (ev == EV_ERROR)
        begin
            role = ROLE_NONE;
        end
    end

    always_comb
    begin
        mem_wa = AW'(int'(dep_next) * MAX_NAME + int'(ni_reg));
        if (st_reg == ST_LT)
        begin
            mem_wa = AW'(int'(dep_next) * MAX_NAME);
        end
        mem_ra = AW'((int'(dep_next) - 1) * MAX_NAME + int'(ni_next));
    end

    always_comb
    begin
        res.event_res   = ev;
        res.error_code  = (ev == EV_ERROR) ? err_next : ERR_NONE;
        res.depth       = 5'(dep_next);
        res.byte_role   = role;
        res.role_byte   = (role != ROLE_NONE) ? c : 8'd0;
        res.line_number = line_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_OUT;
            pend_reg <= 1'b0;
            dep_reg  <= '0;
            ni_reg   <= '0;
            mis_reg  <= 1'b0;
            err_reg  <= ERR_NONE;
            line_reg <= '0;
        end
        else
        begin
            st_reg   <= st_next;
            pend_reg <= pend_next;
            dep_reg  <= dep_next;
            ni_reg   <= ni_next;
            mis_reg  <= mis_next;
            err_reg  <= err_next;
            line_reg <= line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            name_mem[mem_wa] <= c;
        end
        rd_reg <= name_mem[mem_ra];
        if (len_we)
        begin
            len_reg[TOP_W'(dep_reg)] <= LEN_W'(ni_reg);
        end
    end
endmodule

@@ rtl/xml_tag_tokenizer.sv @@
// ----------------------------------------------------------------------------
// xml_tag_tokenizer
// Streaming XML tag tokenizer with a bounded name stack for end-tag checks.
// ----------------------------------------------------------------------------
// An accepted byte is registered in the input queue, handled by the tag state
// machine and registered in the result queue. Throughput: one byte per cycle
// while the result queue has room; the end-tag compare reads one prefetched
// name-stack byte per input byte from a single registered memory port.
// Reset clears the parser, queues, depth, line count and sticky error; the
// name stack memory is not cleared and needs no clearing pass.
module xml_tag_tokenizer #(
    parameter int MAX_DEPTH = xtt_pkg::MAX_DEPTH_DEF,
    parameter int MAX_NAME  = xtt_pkg::MAX_NAME_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  event_res,
    output logic [3:0]  error_code,
    output logic [4:0]  depth,
    output logic [2:0]  byte_role,
    output logic [7:0]  role_byte,
    output logic [19:0] line_number
);
    import xtt_pkg::*;

    logic  item_valid;
    item_t item;
    logic  item_take;
    logic  res_full;
    logic  res_wr;
    res_t  res_in;
    res_t  res_out;

    xtt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .full        (full),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take)
    );

    xtt_back #(
        .MAX_DEPTH (MAX_DEPTH),
        .MAX_NAME  (MAX_NAME)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_full   (res_full),
        .res_wr     (res_wr),
        .res        (res_in)
    );

    xtt_fifo #(.W($bits(res_t))) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign event_res   = res_out.event_res;
    assign error_code  = res_out.error_code;
    assign depth       = res_out.depth;
    assign byte_role   = res_out.byte_role;
    assign role_byte   = res_out.role_byte;
    assign line_number = res_out.line_number;
endmodule

@@ tb/xml_tag_tokenizer_test.sv @@
// ----------------------------------------------------------------------------
// xml_tag_tokenizer_test
// Self-checking testbench for the streaming XML tag tokenizer. A directed
// document is followed by random well-formed markup with random content:
// nested elements up to the stack limit, attributes, comments, processing
// instructions and declarations. End-of-text marks are mixed in. A final
// broken construct raises one error and checks that it sticks. Each
// transaction is checked field by field against a predictor of the parser.
// ----------------------------------------------------------------------------
module xml_tag_tokenizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import xtt_pkg::*;

    localparam int DEPTH_LIM = MAX_DEPTH_DEF;
    localparam int NAME_LIM  = MAX_NAME_DEF;
    localparam int ITEM_GOAL = 1500;
    localparam int WATCHDOG  = 3000;

    typedef struct packed {
        logic [7:0] b;
        logic       e;
    } text_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  text_byte = 8'h00;
    logic        end_of_text = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  event_res;
    logic [3:0]  error_code;
    logic [4:0]  depth;
    logic [2:0]  byte_role;
    logic [7:0]  role_byte;
    logic [19:0] line_number;

    xml_tag_tokenizer uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .text_byte(text_byte), .end_of_text(end_of_text),
        .empty(empty), .pop(pop), .event_res(event_res),
        .error_code(error_code), .depth(depth), .byte_role(byte_role),
        .role_byte(role_byte), .line_number(line_number)
    );

    text_item_t pending_text[$];
    res_t       expected_tokens[$];

    // Predictor state.
    st_t        parse_st;
    bit         close_pending;
    int         open_count;
    logic [7:0] open_chars[DEPTH_LIM][NAME_LIM];
    int         open_len[DEPTH_LIM];
    int         etag_pos;
    bit         etag_bad;
    err_t       held_err;
    logic [19:0] newlines;

    // Generator state.
    logic [7:0] gen_chars[DEPTH_LIM][NAME_LIM];
    int         gen_len[DEPTH_LIM];
    int         gen_depth;
    int         planned_err;

    int total_items, sent_items, got_tokens, mismatches, deepest;
    int send_idle_pct, recv_stall_pct, hold_left, idle_cycles;
    bit hold_done;

    initial begin
        forever #4 clk = ~clk;
    end

    task automatic tokenize_byte(input logic [7:0] c, input logic eot, output res_t r);
        event_t ev;
        role_t  role;
        bit     done;
        int     top;
        ev = EV_NONE;
        role = ROLE_NONE;
        done = 1'b0;
        if (!eot && c == CH_NL && newlines != LINE_MAX)
            newlines++;
        if (held_err != ERR_NONE) begin
            ev = EV_ERROR;
            done = 1'b1;
        end
        if (!done && close_pending) begin
            close_pending = 1'b0;
            if (open_count == 0) begin
                held_err = ERR_UNDERFLOW;
                ev = EV_ERROR;
                done = 1'b1;
            end
            else
                open_count--;
        end
        if (!done && eot) begin
            ev = EV_EOT;
            done = 1'b1;
        end
        if (!done) begin
            case (parse_st)
                ST_LT:
                    if (c == CH_SLASH)
                    begin
                        parse_st = ST_ETAG;
                        etag_pos = 0;
                        etag_bad = 1'b0;
                    end
                    else if (c == CH_QM) parse_st = ST_PI;
                    else if (c == CH_EXCL) parse_st = ST_DECL;
                    else if (c > CH_SP)
                    begin
                        if (open_count >= DEPTH_LIM)
                        begin
                            held_err = ERR_OVERFLOW;
                            ev = EV_ERROR;
                        end
                        else
                        begin
                            open_chars[open_count][0] = c;
                            etag_pos = 1;
                            parse_st = ST_NAME;
                            role = ROLE_TAG;
                        end
                    end
                ST_NAME:
                    if (c == CH_GT || c == CH_SLASH || c <= CH_SP)
                    begin
                        if (open_count >= DEPTH_LIM)
                        begin
                            held_err = ERR_OVERFLOW;
                            ev = EV_ERROR;
                        end
                        else
                        begin
                            open_len[open_count] = etag_pos;
                            open_count++;
                            if (c == CH_GT)
                            begin
                                parse_st = ST_OUT;
                                ev = EV_START;
                            end
                            else if (c == CH_SLASH)
                            begin
                                parse_st = ST_SLASH;
                                ev = EV_START;
                            end
                            else parse_st = ST_SPACE;
                        end
                    end
                    else if (etag_pos >= NAME_LIM || open_count >= DEPTH_LIM)
                    begin
                        held_err = ERR_LONG_NAME;
                        ev = EV_ERROR;
                    end
                    else
                    begin
                        open_chars[open_count][etag_pos] = c;
                        etag_pos++;
                        role = ROLE_TAG;
                    end
                ST_SPACE:
                    if (c == CH_GT)
                    begin
                        parse_st = ST_OUT;
                        ev = EV_START;
                    end
                    else if (c == CH_SLASH)
                    begin
                        parse_st = ST_SLASH;
                        ev = EV_START;
                    end
                    else if (c > CH_SP)
                    begin
                        parse_st = ST_ANAME;
                        role = ROLE_ANAME;
                    end
                ST_ANAME:
                    if (c == CH_EQ) parse_st = ST_EQ;
                    else if (c > CH_SP) role = ROLE_ANAME;
                    else
                    begin
                        held_err = ERR_ATTR_SP;
                        ev = EV_ERROR;
                    end
                ST_EQ:
                    if (c == CH_DQ) parse_st = ST_VAL;
                    else if (c > CH_SP)
                    begin
                        held_err = ERR_BAD_QUOTE;
                        ev = EV_ERROR;
                    end
                ST_VAL:
                    if (c == CH_DQ)
                    begin
                        parse_st = ST_SPACE;
                        ev = EV_ATTR;
                    end
                    else role = ROLE_AVAL;
                ST_SLASH:
                    if (c == CH_GT)
                    begin
                        parse_st = ST_OUT;
                        close_pending = 1'b1;
                        ev = EV_END;
                    end
                    else
                    begin
                        held_err = ERR_BAD_SLASH;
                        ev = EV_ERROR;
                    end
                ST_ETAG, ST_ETAG_SP:
                    if (c == CH_GT)
                    begin
                        if (open_count == 0)
                        begin
                            held_err = ERR_UNDERFLOW;
                            ev = EV_ERROR;
                        end
                        else
                        begin
                            top = open_count - 1;
                            parse_st = ST_OUT;
                            if (etag_bad || etag_pos != open_len[top])
                            begin
                                held_err = ERR_MISMATCH;
                                ev = EV_ERROR;
                            end
                            else
                            begin
                                close_pending = 1'b1;
                                ev = EV_END;
                            end
                        end
                    end
                    else if (c > CH_SP && parse_st == ST_ETAG_SP)
                    begin
                        held_err = ERR_END_GARB;
                        ev = EV_ERROR;
                    end
                    else if (c > CH_SP)
                    begin
                        if (open_count == 0)
                            etag_bad = 1'b1;
                        else
                        begin
                            top = open_count - 1;
                            if (etag_pos >= open_len[top] || etag_pos >= NAME_LIM)
                                etag_bad = 1'b1;
                            else if (open_chars[top][etag_pos] != c)
                                etag_bad = 1'b1;
                        end
                        if (etag_pos <= NAME_LIM)
                            etag_pos++;
                        role = ROLE_ETAG;
                    end
                    else parse_st = ST_ETAG_SP;
                ST_PI:
                    if (c == CH_QM) parse_st = ST_PI_Q;
                ST_PI_Q:
                    parse_st = (c == CH_GT) ? ST_OUT : ST_PI;
                ST_DECL:
                    if (c == CH_DASH) parse_st = ST_CM0;
                    else if (c == CH_LBR) parse_st = ST_BR;
                    else if (c == CH_DQ) parse_st = ST_DQ;
                    else parse_st = ST_DECL2;
                ST_DECL2:
                    if (c == CH_GT) parse_st = ST_OUT;
                    else if (c == CH_LBR) parse_st = ST_BR;
                    else if (c == CH_DQ) parse_st = ST_DQ;
                ST_CM0:
                    if (c == CH_DASH) parse_st = ST_CM;
                    else
                    begin
                        held_err = ERR_COMMENT;
                        ev = EV_ERROR;
                    end
                ST_CM:
                    if (c == CH_DASH) parse_st = ST_CM1;
                ST_CM1:
                    parse_st = (c == CH_DASH) ? ST_CM2 : ST_CM;
                ST_CM2:
                    parse_st = (c == CH_GT) ? ST_OUT : ST_CM;
                ST_BR:
                    if (c == CH_RBR) parse_st = ST_DECL2;
                    else if (c == CH_DQ) parse_st = ST_BRQ;
                ST_BRQ:
                    if (c == CH_DQ) parse_st = ST_BR;
                ST_DQ:
                    if (c == CH_DQ) parse_st = ST_DECL2;
                default:
                    parse_st = (c == CH_LT) ? ST_LT : ST_OUT;
            endcase
        end
        if (ev == EV_ERROR)
            role = ROLE_NONE;
        r.event_res   = ev;
        r.error_code  = (ev == EV_ERROR) ? held_err : ERR_NONE;
        r.depth       = open_count[4:0];
        r.byte_role   = role;
        r.role_byte   = (role != ROLE_NONE) ? c : 8'h00;
        r.line_number = newlines;
        if (open_count > deepest)
            deepest = open_count;
    endtask

    function automatic logic [7:0] pick_byte(input logic [7:0] lo, input logic [7:0] x1,
                                             input logic [7:0] x2, input logic [7:0] x3,
                                             input logic [7:0] x4);
        logic [7:0] v;
        do
            v = 8'($urandom_range(255, lo));
        while (v == x1 || v == x2 || v == x3 || v == x4);
        return v;
    endfunction

    task automatic append_text(input text_item_t t);
        pending_text = {pending_text, t};
    endtask

    task automatic put(input logic [7:0] b);
        if ($urandom_range(199) == 0)
            append_text('{8'($urandom_range(255)), 1'b1});
        append_text('{b, 1'b0});
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endtask

    task automatic put_ws();
        put(8'($urandom_range(32)));
    endtask

    task automatic open_element(input int len, input bit self_close);
        int n;
        put(CH_LT);
        if ($urandom_range(99) < 15)
            put_ws();
        for (int i = 0; i < len; i++)
        begin
            if (i == 0)
                gen_chars[gen_depth][i] = pick_byte(8'h21, CH_GT, CH_SLASH, CH_QM, CH_EXCL);
            else
                gen_chars[gen_depth][i] = pick_byte(8'h21, CH_GT, CH_SLASH, CH_GT, CH_GT);
            put(gen_chars[gen_depth][i]);
        end
        gen_len[gen_depth] = len;
        n = $urandom_range(3);
        for (int a = 0; a < n; a++)
        begin
            put_ws();
            put(pick_byte(8'h21, CH_GT, CH_SLASH, CH_EQ, CH_EQ));
            repeat ($urandom_range(3))
                put(pick_byte(8'h21, CH_EQ, CH_EQ, CH_EQ, CH_EQ));
            put(CH_EQ);
            if ($urandom_range(1))
                put_ws();
            put(CH_DQ);
            repeat ($urandom_range(5))
                put(pick_byte(8'h00, CH_DQ, CH_DQ, CH_DQ, CH_DQ));
            put(CH_DQ);
        end
        if (self_close)
        begin
            if (n == 0 && $urandom_range(1))
                put_ws();
            put(CH_SLASH);
            put(CH_GT);
        end
        else
        begin
            put(CH_GT);
            gen_depth++;
        end
    endtask

    task automatic close_element();
        gen_depth--;
        put(CH_LT);
        put(CH_SLASH);
        for (int i = 0; i < gen_len[gen_depth]; i++)
            put(gen_chars[gen_depth][i]);
        if ($urandom_range(3) == 0)
            put_ws();
        put(CH_GT);
    endtask

    task automatic build_markup();
        int r;
        while (pending_text.size() < ITEM_GOAL)
        begin
            r = $urandom_range(99);
            if (r < 30 && gen_depth < DEPTH_LIM)
                open_element(($urandom_range(19) == 0) ? NAME_LIM : $urandom_range(1, 6),
                             $urandom_range(4) == 0);
            else if (r < 55 && gen_depth > 0)
                close_element();
            else if (r < 75)
                repeat ($urandom_range(1, 8))
                    put(pick_byte(8'h00, CH_LT, CH_LT, CH_LT, CH_LT));
            else if (r < 82)
            begin
                put_str("<!--");
                repeat ($urandom_range(6))
                    put(pick_byte(8'h00, CH_DASH, CH_DASH, CH_DASH, CH_DASH));
                put_str("-->");
            end
            else if (r < 88)
            begin
                put_str("<?");
                repeat ($urandom_range(6))
                    put(pick_byte(8'h00, CH_QM, CH_QM, CH_QM, CH_QM));
                put_str("?>");
            end
            else if (r < 94)
            begin
                put_str("<!D");
                repeat ($urandom_range(4))
                    put(pick_byte(8'h00, CH_GT, CH_LBR, CH_DQ, CH_DASH));
                if ($urandom_range(1))
                begin
                    put(CH_LBR);
                    repeat ($urandom_range(4))
                        put(pick_byte(8'h00, CH_RBR, CH_DQ, CH_DQ, CH_DQ));
                    put_str("\"]x\"]");
                end
                else
                    put_str("\"a>\"");
                put(CH_GT);
            end
            else
                append_text('{8'($urandom_range(255)), 1'b1});
        end
    endtask

    task automatic build_error_tail();
        while (gen_depth > 0)
            close_element();
        planned_err = $urandom_range(ERR_ATTR_SP, ERR_LONG_NAME);
        case (err_t'(planned_err))
            ERR_ATTR_SP:   put_str("<a b c");
            ERR_BAD_QUOTE: put_str("<a b=x");
            ERR_BAD_SLASH: put_str("<a/x");
            ERR_MISMATCH:
                if ($urandom_range(1))
                    put_str("<a></b>");
                else
                begin
                    put_str("<a></");
                    repeat (NAME_LIM + 8)
                        put("a");
                    put(CH_GT);
                end
            ERR_END_GARB:  put_str("<a></a x>");
            ERR_COMMENT:   put_str("<!-x");
            ERR_UNDERFLOW: put_str("</q>");
            ERR_OVERFLOW:
            begin
                repeat (DEPTH_LIM)
                    put_str("<q>");
                put_str("<q");
            end
            default:
            begin
                put(CH_LT);
                repeat (NAME_LIM + 1)
                    put("n");
            end
        endcase
        repeat (10)
            put(($urandom_range(2) == 0) ? CH_NL : 8'($urandom_range(255)));
        append_text('{8'hFF, 1'b1});
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        res_t       r;
        text_item_t it;
        int         phase;
        if (!rst_n)
        begin
            push <= 1'b0;
            text_byte <= 8'h00;
            end_of_text <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                tokenize_byte(text_byte, end_of_text, r);
                expected_tokens = {expected_tokens, r};
                sent_items++;
            end
            phase = (sent_items * 4) / total_items;
            send_idle_pct = (phase == 1) ? 59 : (phase == 3) ? 26 : 0;
            recv_stall_pct = (phase == 2) ? 59 : (phase == 3) ? 26 : 0;
            if (!push || !full)
            begin
                if (pending_text.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    it = pending_text.pop_front();
                    push <= 1'b1;
                    text_byte <= it.b;
                    end_of_text <= it.e;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        res_t act, exp;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                got_tokens++;
                act = '{event_t'(event_res), err_t'(error_code), depth,
                        role_t'(byte_role), role_byte, line_number};
                if (expected_tokens.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected transaction: ev=%0d err=%0d depth=%0d",
                                 event_res, error_code, depth);
                end
                else
                begin
                    exp = expected_tokens.pop_front();
                    if (act.event_res !== exp.event_res || act.error_code !== exp.error_code
                        || act.depth !== exp.depth || act.byte_role !== exp.byte_role
                        || act.role_byte !== exp.role_byte
                        || act.line_number !== exp.line_number)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Mismatch at token %0d: expected ev=%0d err=%0d depth=%0d",
                                      " role=%0d byte=%h line=%0d, got ev=%0d err=%0d",
                                      " depth=%0d role=%0d byte=%h line=%0d"},
                                     got_tokens, exp.event_res, exp.error_code, exp.depth,
                                     exp.byte_role, exp.role_byte, exp.line_number,
                                     act.event_res, act.error_code, act.depth,
                                     act.byte_role, act.role_byte, act.line_number);
                    end
                end
            end
            if (!hold_done && sent_items >= total_items / 8)
            begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("Timeout: no transaction for %0d cycles.", WATCHDOG);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        parse_st = ST_OUT;
        close_pending = 1'b0;
        open_count = 0;
        etag_pos = 0;
        etag_bad = 1'b0;
        held_err = ERR_NONE;
        newlines = '0;
        gen_depth = 0;
        foreach (open_len[i])
            open_len[i] = 0;
        put_str("<?x?><!--c--><![\"]\"]>< r k= \"\377\"><e/></r>\n");
        append_text('{8'h0A, 1'b1});
        build_markup();
        build_error_tail();
        total_items = pending_text.size();
        repeat (2) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;
        wait (pending_text.size() == 0 && !push);
        wait (expected_tokens.size() == 0);
        repeat (20) @(posedge clk);
        $display("Sent %0d text items, checked %0d tokens, deepest nesting %0d.",
                 sent_items, got_tokens, deepest);
        $display("Closing malformed construct held error code %0d, %0d mismatches.",
                 planned_err, mismatches);
        if (mismatches == 0 && expected_tokens.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/xtt_pkg.sv
rtl/xtt_fifo.sv
rtl/xtt_front.sv
rtl/xtt_back.sv
rtl/xml_tag_tokenizer.sv
tb/xml_tag_tokenizer_test.sv
